/* src/tcw_pkg.sv */
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Widest cell address for the largest screen that the parameters allow.
    localparam int MAX_ADDR_W  = 16;
    localparam int CELL_W      = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } t_opcode;

    localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'd1;

    localparam logic [CFG_DATA_W-1:0] FOREGROUND_RESET = 4'd7;
    localparam logic [CFG_DATA_W-1:0] BACKGROUND_RESET = 4'd0;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_BLANK = 8'h20;

    localparam logic [CELL_W-1:0] RESET_CELL = {FOREGROUND_RESET & 4'h0, 4'h0, CH_BLANK}
                                               | 16'h0700;

    typedef struct packed {
        logic                  we;
        logic [MAX_ADDR_W-1:0] waddr;
        logic [CELL_W-1:0]     wdata;
        logic [MAX_ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

/* src/tcw_in_if.sv */
interface tcw_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [7:0]  new_column;
    logic [7:0]  new_row;
    logic [10:0] cell_address;

    modport source (output valid, opcode, char_code, new_column, new_row, cell_address,
                    input ready);
    modport sink   (input valid, opcode, char_code, new_column, new_row, cell_address,
                    output ready);
endinterface

/* src/tcw_out_if.sv */
interface tcw_out_if;
    logic        valid;
    logic        ready;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_position;
    logic [15:0] cell_value;

    modport source (output valid, cursor_column, cursor_row, cursor_position, cell_value,
                    input ready);
    modport sink   (input valid, cursor_column, cursor_row, cursor_position, cell_value,
                    output ready);
endinterface

/* src/tcw_screen_mem.sv */
module tcw_screen_mem #(
    parameter int DEPTH  = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                   i_clk,
    input  tcw_pkg::t_mem_req      i_req,
    output logic [tcw_pkg::CELL_W-1:0] o_rdata
);

    logic [tcw_pkg::CELL_W-1:0] r_mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[ADDR_W-1:0]] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr[ADDR_W-1:0]];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/tcw_seq.sv */
module tcw_seq #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [7:0]                 i_attr,
    tcw_in_if.sink                     i_cmd,
    tcw_out_if.source                  o_res,
    output tcw_pkg::t_mem_req          o_mem,
    input  logic [tcw_pkg::CELL_W-1:0] i_rdata
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int SW_W   = ADDR_W + 1;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam logic [SW_W-1:0]  SW_CELLS  = SW_W'(CELLS);
    localparam logic [SW_W-1:0]  SW_LAST   = SW_W'(CELLS - 1);
    localparam logic [SW_W-1:0]  SW_ROW1   = SW_W'(COLUMNS);
    localparam logic [SW_W-1:0]  SW_BOTTOM = SW_W'((ROWS - 1) * COLUMNS);
    localparam logic [COL_W:0]   COL_LIMIT = (COL_W + 1)'(COLUMNS);
    localparam logic [COL_W-1:0] COL_MAX   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_MAX   = ROW_W'(ROWS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCROLL,
        S_FILL,
        S_DONE
    } t_state;

    t_state                     r_state;
    logic [COL_W-1:0]           r_col;
    logic [ROW_W-1:0]           r_row;
    tcw_pkg::t_opcode           r_op;
    logic [7:0]                 r_ch;
    logic [7:0]                 r_nc;
    logic [7:0]                 r_nr;
    logic [10:0]                r_addr;
    logic [SW_W-1:0]            r_sweep;
    logic                       r_copy_pend;
    logic [ADDR_W-1:0]          r_copy_dst;
    logic [tcw_pkg::CELL_W-1:0] r_fill;
    logic                       r_init;
    logic                       r_oob;
    logic [tcw_pkg::CELL_W-1:0] r_val;

    logic                       r_out_valid;
    logic [6:0]                 r_out_col;
    logic [4:0]                 r_out_row;
    logic [10:0]                r_out_pos;
    logic [15:0]                r_out_val;

    logic [ADDR_W-1:0]          cur_pos;
    logic [COL_W:0]             inc_col;
    logic [COL_W:0]             tab_col;
    logic [tcw_pkg::CELL_W-1:0] blank;
    logic                       is_ctrl;
    logic                       do_newline;

    assign cur_pos = ADDR_W'(32'(r_row) * COLUMNS + 32'(r_col));
    assign inc_col = {1'b0, r_col} + (COL_W + 1)'(1);
    assign tab_col = ({1'b0, r_col} + (COL_W + 1)'(4)) & ~(COL_W + 1)'(3);
    assign blank   = {i_attr, tcw_pkg::CH_BLANK};
    assign is_ctrl = (r_ch == tcw_pkg::CH_LF) || (r_ch == tcw_pkg::CH_CR)
                  || (r_ch == tcw_pkg::CH_TAB) || (r_ch == tcw_pkg::CH_BS);

    // A line feed, a tab past the last stop, or a character in the last column
    // all end in the same newline and possibly a scroll.
    assign do_newline = (r_ch == tcw_pkg::CH_LF)
                     || ((r_ch == tcw_pkg::CH_TAB) && (tab_col >= COL_LIMIT))
                     || (!is_ctrl && (inc_col >= COL_LIMIT));

    always_comb begin
        o_mem = '0;
        unique case (r_state)
            S_EXEC: begin
                if (r_op == tcw_pkg::OP_PUT) begin
                    if ((r_ch == tcw_pkg::CH_BS) && (r_col != '0)) begin
                        o_mem.we    = 1'b1;
                        o_mem.waddr = tcw_pkg::MAX_ADDR_W'(cur_pos - ADDR_W'(1));
                        o_mem.wdata = blank;
                    end else if (!is_ctrl) begin
                        o_mem.we    = 1'b1;
                        o_mem.waddr = tcw_pkg::MAX_ADDR_W'(cur_pos);
                        o_mem.wdata = {i_attr, r_ch};
                    end
                end
                o_mem.raddr = tcw_pkg::MAX_ADDR_W'(r_addr);
            end
            S_SCROLL: begin
                // The copy write of a cell comes in the cycle after its source read.
                if (r_sweep != SW_CELLS) begin
                    o_mem.raddr = tcw_pkg::MAX_ADDR_W'(r_sweep);
                end
                o_mem.we    = r_copy_pend;
                o_mem.waddr = tcw_pkg::MAX_ADDR_W'(r_copy_dst);
                o_mem.wdata = i_rdata;
            end
            S_FILL: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = tcw_pkg::MAX_ADDR_W'(r_sweep);
                o_mem.wdata = r_fill;
            end
            default: begin
                o_mem = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_col       <= '0;
            r_row       <= '0;
            r_sweep     <= '0;
            r_fill      <= tcw_pkg::RESET_CELL;
            r_init      <= 1'b1;
            r_copy_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // In S_DONE the output register is refilled below instead.
            if (r_out_valid && o_res.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_op    <= tcw_pkg::t_opcode'(i_cmd.opcode);
                        r_ch    <= i_cmd.char_code;
                        r_nc    <= i_cmd.new_column;
                        r_nr    <= i_cmd.new_row;
                        r_addr  <= i_cmd.cell_address;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_val <= '0;
                    unique case (r_op)
                        tcw_pkg::OP_PUT: begin
                            if (do_newline) begin
                                r_col <= '0;
                                if (r_row == ROW_MAX) begin
                                    r_fill      <= blank;
                                    r_sweep     <= SW_ROW1;
                                    r_copy_pend <= 1'b0;
                                    r_state     <= S_SCROLL;
                                end else begin
                                    r_row   <= r_row + ROW_W'(1);
                                    r_state <= S_DONE;
                                end
                            end else begin
                                case (r_ch)
                                    tcw_pkg::CH_CR: r_col <= '0;
                                    tcw_pkg::CH_TAB: r_col <= COL_W'(tab_col);
                                    tcw_pkg::CH_BS: begin
                                        if (r_col != '0) begin
                                            r_col <= r_col - COL_W'(1);
                                        end
                                    end
                                    default: r_col <= COL_W'(inc_col);
                                endcase
                                r_state <= S_DONE;
                            end
                        end
                        tcw_pkg::OP_SET: begin
                            r_col   <= (32'(r_nc) >= COLUMNS) ? COL_MAX : COL_W'(r_nc);
                            r_row   <= (32'(r_nr) >= ROWS) ? ROW_MAX : ROW_W'(r_nr);
                            r_state <= S_DONE;
                        end
                        tcw_pkg::OP_CLEAR: begin
                            r_col   <= '0;
                            r_row   <= '0;
                            r_fill  <= blank;
                            r_sweep <= '0;
                            r_state <= S_FILL;
                        end
                        tcw_pkg::OP_READ: begin
                            r_oob   <= 32'(r_addr) >= CELLS;
                            r_state <= S_READ;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_READ: begin
                    r_val   <= r_oob ? '0 : i_rdata;
                    r_state <= S_DONE;
                end
                S_SCROLL: begin
                    r_copy_pend <= (r_sweep != SW_CELLS);
                    r_copy_dst  <= ADDR_W'(r_sweep - SW_ROW1);
                    if (r_sweep == SW_CELLS) begin
                        r_sweep <= SW_BOTTOM;
                        r_state <= S_FILL;
                    end else begin
                        r_sweep <= r_sweep + SW_W'(1);
                    end
                end
                S_FILL: begin
                    if (r_sweep == SW_LAST) begin
                        r_init  <= 1'b0;
                        r_state <= r_init ? S_IDLE : S_DONE;
                    end else begin
                        r_sweep <= r_sweep + SW_W'(1);
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_col   <= 7'(r_col);
                        r_out_row   <= 5'(r_row);
                        r_out_pos   <= 11'(cur_pos);
                        r_out_val   <= r_val;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_cmd.ready           = (r_state == S_IDLE);
    assign o_res.valid           = r_out_valid;
    assign o_res.cursor_column   = r_out_col;
    assign o_res.cursor_row      = r_out_row;
    assign o_res.cursor_position = r_out_pos;
    assign o_res.cell_value      = r_out_val;

endmodule

/* src/text_console_writer_core.sv */
// Text console writer: a character screen of attribute/character cells and a cursor.
// Commands arrive on i_cmd (valid/ready); each command yields exactly one result
// transaction on o_res carrying the cursor after the command, its linear position,
// and for a cell read the 16-bit cell (attribute high byte, character low byte).
// The colors are written through the plain write port i_cfg_we/i_cfg_index/i_cfg_data.
// The user must write them only while no command is in flight; the block itself does
// not enforce this. They set the attribute of every later character write and of the
// blanks of later backspaces, scrolls and clears. The screen sits in one synchronous
// memory with one write and one read port. A newline on the last row scrolls: it
// copies one cell per cycle and blanks the bottom row. Clear screen blanks every cell
// and homes the cursor. One command is worked on at a time; scroll and clear are the
// long cases, set by the memory sweep. After reset the block blanks the screen with
// attribute 0x07 and accepts no command until that pass ends. Results sit in an output
// register: while the receiver stalls, the next command is still accepted and
// executed, and its result waits until the register frees.
module text_console_writer_core #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tcw_in_if.sink                            i_cmd,
    tcw_out_if.source                         o_res,
    input  logic                              i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CELLS = COLUMNS * ROWS;

    logic [tcw_pkg::CFG_DATA_W-1:0] r_fg;
    logic [tcw_pkg::CFG_DATA_W-1:0] r_bg;
    tcw_pkg::t_mem_req              mem_req;
    logic [tcw_pkg::CELL_W-1:0]     mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= tcw_pkg::FOREGROUND_RESET;
            r_bg <= tcw_pkg::BACKGROUND_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tcw_pkg::CFG_FOREGROUND: r_fg <= i_cfg_data;
                tcw_pkg::CFG_BACKGROUND: r_bg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tcw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_attr  ({r_bg, r_fg}),
        .i_cmd   (i_cmd),
        .o_res   (o_res),
        .o_mem   (mem_req),
        .i_rdata (mem_rdata)
    );

    tcw_screen_mem #(
        .DEPTH  (CELLS),
        .ADDR_W ($clog2(CELLS))
    ) u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

/* src/tcw_checker.sv */
module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [6:0]  i_cursor_column,
    input logic [4:0]  i_cursor_row,
    input logic [10:0] i_cursor_position,
    input logic [15:0] i_cell_value
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_cursor_position) && $stable(i_cell_value))
        else $error("result payload changed while stalled");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (32'(i_cursor_column) < COLUMNS) && (32'(i_cursor_row) < ROWS))
        else $error("cursor outside the screen");

    // The linear position has to agree with the reported row and column.
    a_cursor_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            i_cursor_position == 11'(32'(i_cursor_row) * COLUMNS + 32'(i_cursor_column)))
        else $error("cursor position does not match row and column");

endmodule

bind text_console_writer_core tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_res.valid),
    .i_out_ready       (o_res.ready),
    .i_cursor_column   (o_res.cursor_column),
    .i_cursor_row      (o_res.cursor_row),
    .i_cursor_position (o_res.cursor_position),
    .i_cell_value      (o_res.cell_value)
);
